@@ design/hsed_pkg.sv @@
// Shared widths, stage payload types and position tables for the Hamming decoder.
`default_nettype none

package hsed_pkg;

  // Field widths
  localparam int CW_W        = 63;
  localparam int LEN_W       = 6;
  localparam int DATA_W      = 57;
  localparam int PCNT_W      = 3;
  localparam int DEF_MAX_LEN = 63;

  // After masking and length saturation
  typedef struct packed {
    logic [CW_W-1:0]  word;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] dlen;
  } hsed_word_t;

  // After syndrome computation
  typedef struct packed {
    logic [CW_W-1:0]  word;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] dlen;
    logic [LEN_W-1:0] syn;
  } hsed_syn_t;

  // After correction
  typedef struct packed {
    logic [CW_W-1:0]  word;
    logic [LEN_W-1:0] dlen;
    logic [LEN_W-1:0] syn;
    logic             fix;
    logic             oor;
  } hsed_fix_t;

  // Final result
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  dlen;
    logic [LEN_W-1:0]  syn;
    logic              fix;
    logic              oor;
  } hsed_result_t;

  // Bit k set when Hamming position k+1 has syndrome bit b set
  function automatic logic [CW_W-1:0] pos_mask(input int b);
    logic [CW_W-1:0] m;
    m = '0;
    for (int p = 0; p < CW_W; p++) begin
      m[p] = (((p + 1) >> b) & 1) != 0;
    end
    return m;
  endfunction

  // Word index of the j-th non-parity position
  function automatic logic [LEN_W-1:0] data_pos(input int j);
    int cnt;
    logic [LEN_W-1:0] res;
    cnt = 0;
    res = '0;
    for (int p = 1; p <= CW_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == j) begin
          res = LEN_W'(p - 1);
        end
        cnt = cnt + 1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/hamming_single_error_decoder_core.sv @@
// Hamming single-error-correcting decoder: top level and stage chain.
//
// Usage: present a received even-parity codeword (bit k = position k+1)
// and its length on the input channel with in_valid; a transfer happens
// on a clock edge with in_valid high and in_stall low. One result per
// codeword appears on the output channel with out_valid; the receiver
// holds out_stall high to keep it.
// From input transfer to out_valid a codeword passes the length mask,
// syndrome XOR trees, correction, compaction into the output register.
// Throughput is one codeword per cycle while out_stall is low; every
// stage carries its own valid bit, so a bubble anywhere is filled while
// the output waits. When the receiver stalls, stages fill up one by one;
// in_stall rises only once all four stages hold a codeword, and nothing is
// dropped or repeated. Lengths above MAX_LEN are saturated to it.
// Reset (rst, synchronous) empties all stages; no results are pending
// afterwards and the block takes a transfer in the next cycle.
`default_nettype none

module hamming_single_error_decoder_core #(
  parameter int MAX_LEN = hsed_pkg::DEF_MAX_LEN
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [hsed_pkg::CW_W-1:0]    codeword_bits,
  input  wire logic [hsed_pkg::LEN_W-1:0]   codeword_length,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [hsed_pkg::DATA_W-1:0]       data_bits,
  output logic [hsed_pkg::LEN_W-1:0]        data_length,
  output logic [hsed_pkg::LEN_W-1:0]        syndrome,
  output logic                              corrected,
  output logic                              out_of_range
);

  logic                    s1_ready, s2_ready, s3_ready, s4_ready;
  logic                    s1_valid, s2_valid, s3_valid;
  hsed_pkg::hsed_word_t    s1_data;
  hsed_pkg::hsed_syn_t     s2_data;
  hsed_pkg::hsed_fix_t     s3_data;
  hsed_pkg::hsed_result_t  res;

  assign in_stall = !s1_ready;

  // Stage chain
  hsed_mask_stage #(
    .MAX_LEN(MAX_LEN)
  ) u_mask (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (s1_ready),
    .codeword_bits   (codeword_bits),
    .codeword_length (codeword_length),
    .out_valid       (s1_valid),
    .out_ready       (s2_ready),
    .out_data        (s1_data)
  );

  hsed_syndrome_stage u_syn (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s2_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s3_ready),
    .out_data  (s2_data)
  );

  hsed_correct_stage u_fix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s3_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s4_ready),
    .out_data  (s3_data)
  );

  hsed_extract_stage u_ext (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s4_ready),
    .in_data   (s3_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_data  (res)
  );

  // Result fields
  assign data_bits    = res.data;
  assign data_length  = res.dlen;
  assign syndrome     = res.syn;
  assign corrected    = res.fix;
  assign out_of_range = res.oor;

  // Correction and range flag never coexist
  a_fix_oor_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(corrected && out_of_range))
    else $error("corrected and out_of_range both set");

  // A zero syndrome means nothing to report
  a_zero_syn: assert property (@(posedge clk) disable iff (rst)
    (out_valid && syndrome == '0) |-> (!corrected && !out_of_range))
    else $error("flag set with zero syndrome");

  // A nonzero syndrome is either corrected or out of range
  a_nonzero_syn: assert property (@(posedge clk) disable iff (rst)
    (out_valid && syndrome != '0) |-> (corrected || out_of_range))
    else $error("nonzero syndrome without a flag");

  // Bits above the data length are zero
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((data_bits >> data_length) == '0))
    else $error("data bits set above data_length");

  // Input backpressure only when the whole chain is full and the output stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && s1_valid && s2_valid && s3_valid))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

@@ design/hsed_mask_stage.sv @@
// Stage 1: length saturation, masking of unused bits, data length count.
`default_nettype none

module hsed_mask_stage #(
  parameter int MAX_LEN = hsed_pkg::DEF_MAX_LEN
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [hsed_pkg::CW_W-1:0]    codeword_bits,
  input  wire logic [hsed_pkg::LEN_W-1:0]   codeword_length,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output hsed_pkg::hsed_word_t              out_data
);

  logic                            vld;
  hsed_pkg::hsed_word_t            stage;
  hsed_pkg::hsed_word_t            stage_next;
  logic [hsed_pkg::LEN_W-1:0]      len_sat;
  logic [hsed_pkg::PCNT_W-1:0]     par_cnt;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = stage;

  // Saturate length, clear bits past it, count parity positions present
  always_comb begin
    len_sat = (codeword_length > hsed_pkg::LEN_W'(MAX_LEN)) ?
              hsed_pkg::LEN_W'(MAX_LEN) : codeword_length;
    par_cnt = '0;
    for (int k = 0; k < hsed_pkg::LEN_W; k++) begin
      if ((len_sat >> k) != '0) begin
        par_cnt = par_cnt + hsed_pkg::PCNT_W'(1);
      end
    end
    for (int k = 0; k < hsed_pkg::CW_W; k++) begin
      stage_next.word[k] = codeword_bits[k] && (k < int'(len_sat));
    end
    stage_next.len  = len_sat;
    stage_next.dlen = len_sat - hsed_pkg::LEN_W'(par_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

@@ design/hsed_syndrome_stage.sv @@
// Stage 2: syndrome as six XOR reductions over the masked word.
`default_nettype none

module hsed_syndrome_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire hsed_pkg::hsed_word_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output hsed_pkg::hsed_syn_t        out_data
);

  logic                 vld;
  hsed_pkg::hsed_syn_t  stage;
  hsed_pkg::hsed_syn_t  stage_next;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = stage;

  // Each syndrome bit is the parity of positions carrying that bit
  always_comb begin
    stage_next.word = in_data.word;
    stage_next.len  = in_data.len;
    stage_next.dlen = in_data.dlen;
    for (int b = 0; b < hsed_pkg::LEN_W; b++) begin
      stage_next.syn[b] = ^(in_data.word & hsed_pkg::pos_mask(b));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

@@ design/hsed_correct_stage.sv @@
// Stage 3: range check of the syndrome and single-bit flip.
`default_nettype none

module hsed_correct_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hsed_pkg::hsed_syn_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output hsed_pkg::hsed_fix_t       out_data
);

  logic                 vld;
  hsed_pkg::hsed_fix_t  stage;
  hsed_pkg::hsed_fix_t  stage_next;
  logic                 nonzero;
  logic                 in_range;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = stage;

  // Flip the named bit only when it lies inside the codeword
  always_comb begin
    nonzero  = in_data.syn != '0;
    in_range = in_data.syn <= in_data.len;
    stage_next.fix  = nonzero && in_range;
    stage_next.oor  = nonzero && !in_range;
    stage_next.syn  = in_data.syn;
    stage_next.dlen = in_data.dlen;
    for (int k = 0; k < hsed_pkg::CW_W; k++) begin
      stage_next.word[k] = in_data.word[k] ^
                           (stage_next.fix && (in_data.syn == hsed_pkg::LEN_W'(k + 1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

@@ design/hsed_extract_stage.sv @@
// Stage 4: compaction of non-parity positions into the output register.
`default_nettype none

module hsed_extract_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hsed_pkg::hsed_fix_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output hsed_pkg::hsed_result_t    out_data
);

  logic                    vld;
  hsed_pkg::hsed_result_t  stage;
  hsed_pkg::hsed_result_t  stage_next;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = stage;

  // Parity positions are fixed, so compaction is plain wiring
  always_comb begin
    for (int j = 0; j < hsed_pkg::DATA_W; j++) begin
      stage_next.data[j] = in_data.word[hsed_pkg::data_pos(j)];
    end
    stage_next.dlen = in_data.dlen;
    stage_next.syn  = in_data.syn;
    stage_next.fix  = in_data.fix;
    stage_next.oor  = in_data.oor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_hamming_single_error_decoder_core.sv @@
// Self-checking testbench for the Hamming single-error decoder core.
`timescale 1ns / 1ps

module tb_hamming_single_error_decoder_core;

  localparam int DUT_MAX_LEN      = hsed_pkg::DEF_MAX_LEN;
  localparam int IDLE_CYCLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES    = 12;

  // Expected decode of one codeword
  typedef struct packed {
    logic [hsed_pkg::DATA_W-1:0] data;
    logic [hsed_pkg::LEN_W-1:0]  dlen;
    logic [hsed_pkg::LEN_W-1:0]  syn;
    logic                        fix;
    logic                        oor;
  } decode_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [hsed_pkg::CW_W-1:0]   codeword_bits = '0;
  logic [hsed_pkg::LEN_W-1:0]  codeword_length = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [hsed_pkg::DATA_W-1:0] data_bits;
  logic [hsed_pkg::LEN_W-1:0]  data_length;
  logic [hsed_pkg::LEN_W-1:0]  syndrome;
  logic                        corrected;
  logic                        out_of_range;

  decode_t pending_decodes[$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      recv_hold_left = 0;
  int      mismatch_count = 0;
  int      quiet_cycles = 0;

  hamming_single_error_decoder_core u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .codeword_bits   (codeword_bits),
    .codeword_length (codeword_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_bits       (data_bits),
    .data_length     (data_length),
    .syndrome        (syndrome),
    .corrected       (corrected),
    .out_of_range    (out_of_range)
  );

  always #6 clk = ~clk;

  // XOR of the position numbers of all set bits among the first n positions
  function automatic logic [hsed_pkg::LEN_W-1:0] syndrome_of(
      input logic [hsed_pkg::CW_W-1:0] w, input int n);
    int s;
    s = 0;
    for (int p = 1; p <= n; p++) begin
      if (w[p-1]) s = s ^ p;
    end
    return hsed_pkg::LEN_W'(s);
  endfunction

  // Expected decoder output for one codeword
  function automatic decode_t decode_word(input logic [hsed_pkg::CW_W-1:0] w,
                                          input logic [hsed_pkg::LEN_W-1:0] l);
    decode_t                   r;
    logic [hsed_pkg::CW_W-1:0] cw;
    int                        n;
    int                        k;
    n = (int'(l) > DUT_MAX_LEN) ? DUT_MAX_LEN : int'(l);
    cw = '0;
    for (int p = 1; p <= n; p++) cw[p-1] = w[p-1];
    r = '0;
    r.syn = syndrome_of(cw, n);
    if (r.syn != '0) begin
      if (int'(r.syn) <= n) begin
        cw[int'(r.syn)-1] = ~cw[int'(r.syn)-1];
        r.fix = 1'b1;
      end else begin
        r.oor = 1'b1;
      end
    end
    // pack non-parity positions, low first
    k = 0;
    for (int p = 1; p <= n; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (k < hsed_pkg::DATA_W) r.data[k] = cw[p-1];
        k++;
      end
    end
    r.dlen = hsed_pkg::LEN_W'(k);
    return r;
  endfunction

  // Build a clean codeword of length n from data bits
  function automatic logic [hsed_pkg::CW_W-1:0] encode_word(
      input logic [hsed_pkg::DATA_W-1:0] d, input int n);
    logic [hsed_pkg::CW_W-1:0]  w;
    logic [hsed_pkg::LEN_W-1:0] s;
    int                         k;
    w = '0;
    k = 0;
    for (int p = 1; p <= n; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = d[k];
        k++;
      end
    end
    s = syndrome_of(w, n);
    for (int b = 0; b < hsed_pkg::LEN_W; b++) begin
      if (s[b]) w[(1 << b) - 1] = 1'b1;
    end
    return w;
  endfunction

  function automatic logic [hsed_pkg::CW_W-1:0] pos_bit(input int p);
    return hsed_pkg::CW_W'(1) << (p - 1);
  endfunction

  task automatic note_mismatch(input string field_name, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field_name, exp_val, got_val);
    end
  endtask

  // Transfer monitor: predicts on input transfers, checks output transfers
  always @(posedge clk) begin
    decode_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_decodes.push_back(decode_word(codeword_bits, codeword_length));
      end
      if (out_valid && !out_stall) begin
        if (pending_decodes.size() == 0) begin
          note_mismatch("result with nothing pending", '0, 64'(data_bits));
        end else begin
          want = pending_decodes.pop_front();
          if (data_bits !== want.data) note_mismatch("data_bits", 64'(want.data), 64'(data_bits));
          if (data_length !== want.dlen) begin
            note_mismatch("data_length", 64'(want.dlen), 64'(data_length));
          end
          if (syndrome !== want.syn) note_mismatch("syndrome", 64'(want.syn), 64'(syndrome));
          if (corrected !== want.fix) note_mismatch("corrected", 64'(want.fix), 64'(corrected));
          if (out_of_range !== want.oor) begin
            note_mismatch("out_of_range", 64'(want.oor), 64'(out_of_range));
          end
        end
      end
      // watchdog on cycles without any transfer
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_CYCLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_CYCLE_LIMIT);
        $display("hamming_single_error_decoder_core verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      out_stall <= 1'b1;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one codeword; called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [hsed_pkg::CW_W-1:0] w,
                           input logic [hsed_pkg::LEN_W-1:0] l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    codeword_bits   <= w;
    codeword_length <= l;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_all_decoded();
    while (pending_decodes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed codewords with zero, one or two bit errors, some raw noise
  task automatic send_random_item();
    logic [hsed_pkg::CW_W-1:0]   w;
    logic [hsed_pkg::DATA_W-1:0] d;
    logic [hsed_pkg::CW_W-1:0]   above;
    int                          n;
    int                          kind;
    int                          p1;
    int                          p2;
    if ($urandom_range(31) == 0) n = 0;
    else if ($urandom_range(1) == 0) n = $urandom_range(15, 1);
    else n = $urandom_range(63, 1);
    d = hsed_pkg::DATA_W'({$urandom(), $urandom()});
    kind = $urandom_range(99);
    w = encode_word(d, n);
    if (kind >= 85 || n == 0) begin
      w = hsed_pkg::CW_W'({$urandom(), $urandom()});
    end else if (kind >= 20) begin
      p1 = $urandom_range(n, 1);
      w = w ^ pos_bit(p1);
      if (kind >= 70 && n >= 2) begin
        do p2 = $urandom_range(n, 1); while (p2 == p1);
        w = w ^ pos_bit(p2);
      end
    end
    // now and then leave junk above the length
    if ($urandom_range(7) == 0 && n < hsed_pkg::CW_W) begin
      above = hsed_pkg::CW_W'({$urandom(), $urandom()});
      w = w | (above & ~((hsed_pkg::CW_W'(1) << n) - 1));
    end
    send_word(w, hsed_pkg::LEN_W'(n));
  endtask

  // Directed corner cases
  task automatic test_directed_cases();
    logic [hsed_pkg::DATA_W-1:0] alt;
    alt = hsed_pkg::DATA_W'({2{32'hA5A5_5A5A}});
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // zero length ignores every bit
    send_word('1, 6'd0);
    // shortest codewords: clean, error on first parity, error on second parity
    send_word('0, 6'd1);
    send_word(pos_bit(1), 6'd1);
    send_word(pos_bit(2), 6'd2);
    // syndrome past the end: positions 1 and 2 give 3 with length 2
    send_word(pos_bit(1) | pos_bit(2), 6'd2);
    send_word(pos_bit(1) | pos_bit(2) | pos_bit(3), 6'd3);
    // full length extremes
    send_word('0, 6'd63);
    send_word('1, 6'd63);
    send_word(encode_word('1, 63), 6'd63);
    send_word(encode_word(alt, 63), 6'd63);
    // single errors on first, parity, and last positions
    send_word(encode_word(alt, 63) ^ pos_bit(1), 6'd63);
    send_word(encode_word(alt, 63) ^ pos_bit(32), 6'd63);
    send_word(encode_word(~alt, 63) ^ pos_bit(63), 6'd63);
    send_word(encode_word(57'hB, 7) ^ pos_bit(5), 6'd7);
    // bits beyond the length are ignored
    send_word(encode_word(57'h5, 7) | (~hsed_pkg::CW_W'(0) << 7), 6'd7);
    send_word(pos_bit(63), 6'd62);
    // syndrome 7 with length 5
    send_word(pos_bit(3) | pos_bit(4), 6'd5);
    // double errors: miscorrection and syndrome past the end, then single errors in shorter words
    send_word(encode_word(alt, 63) ^ pos_bit(5) ^ pos_bit(6), 6'd63);
    send_word(encode_word(alt, 48) ^ pos_bit(33) ^ pos_bit(16), 6'd48);
    send_word(encode_word(~alt, 32) ^ pos_bit(32), 6'd32);
    send_word(encode_word(alt, 33) ^ pos_bit(33), 6'd33);
    send_word(encode_word('1, 31) ^ pos_bit(17), 6'd31);
    // a length above the bound cannot be formed on a 6-bit field at bound 63
    stop_sending();
    wait_all_decoded();
  endtask

  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_random_item();
    stop_sending();
    wait_all_decoded();
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_left = 300;
    repeat (40) send_random_item();
    stop_sending();
    wait_all_decoded();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_cases();
    test_random_traffic(470, 23, 81);
    test_random_traffic(470, 81, 23);
    test_random_traffic(470, 0, 0);
    test_output_backpressure();
    recv_idle_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_decodes.size() == 0) begin
      $display("hamming_single_error_decoder_core verification clean");
    end else begin
      $display("hamming_single_error_decoder_core verification failed");
    end
    $finish;
  end

endmodule

@@ hamming_single_error_decoder_core.f @@
design/hsed_pkg.sv
design/hsed_mask_stage.sv
design/hsed_syndrome_stage.sv
design/hsed_correct_stage.sv
design/hsed_extract_stage.sv
design/hamming_single_error_decoder_core.sv
bench/tb_hamming_single_error_decoder_core.sv
